>>> src/arp_binding_table_unit_defines.svh
// Assertion macros used by the ARP binding table unit.
`ifndef ARP_BINDING_TABLE_UNIT_DEFINES_SVH
`define ARP_BINDING_TABLE_UNIT_DEFINES_SVH

// Checked on every rising edge of clk, ignored while rst_n is low.
`define ARPBT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ARPBT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/arpbt_pkg.sv
// ----------------------------------------------------------------------------
// arpbt_pkg
// Sizes, field widths and result codes of the ARP binding table.
// ----------------------------------------------------------------------------
`default_nettype none

package arpbt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 7;
    localparam int ENTRY_W = IP_W + MAC_W + TIME_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_EXPIRE = 1'b1;

    typedef logic [2:0] status_t;

    localparam status_t STAT_NEW         = 3'd0;
    localparam status_t STAT_MAC_CHANGED = 3'd1;
    localparam status_t STAT_IP_CHANGED  = 3'd2;
    localparam status_t STAT_UNCHANGED   = 3'd3;
    localparam status_t STAT_FULL        = 3'd4;
    localparam status_t STAT_CONFLICT    = 3'd5;
    localparam status_t STAT_EXPIRED     = 3'd6;

    localparam logic [TIME_W-1:0] DELAY_RESET = 32'd60000;

endpackage

`default_nettype wire

>>> src/arp_binding_table_unit.sv
// ----------------------------------------------------------------------------
// arp_binding_table_unit
// Fixed-capacity IPv4-to-MAC binding table with last-seen times and expiry.
// ----------------------------------------------------------------------------
// Every item, add or expire, scans all CAPACITY entries of the binding RAM
// in index order through its single read port, one entry per cycle. It then
// finishes the last compare, decides and writes back in the decide state,
// and returns to idle, where the next item can be accepted. The decide
// state waits until the result register is free, that is until the
// previous result leaves. Valid bits sit in flip-flops and are cleared by
// reset, so no clearing pass is needed. The result waits in an output
// register; a new item may be accepted while it waits.
`default_nettype none

`include "arp_binding_table_unit_defines.svh"

module arp_binding_table_unit
    import arpbt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [TIME_W-1:0]  cfg_data,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               cmd,
    input  wire logic [IP_W-1:0]    ip_addr,
    input  wire logic [MAC_W-1:0]   mac_addr,
    input  wire logic [TIME_W-1:0]  now_ms,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              status,
    output logic [IP_W-1:0]         old_ip_addr,
    output logic [MAC_W-1:0]        old_mac_addr,
    output logic [COUNT_W-1:0]      expired_count
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    logic [1:0]         state_reg;
    logic [TIME_W-1:0]  delay_reg;

    logic               cmd_reg;
    logic [IP_W-1:0]    ip_reg;
    logic [MAC_W-1:0]   mac_reg;
    logic [TIME_W-1:0]  now_reg;

    logic               valid_reg [CAPACITY];

    logic [CNT_W-1:0]   issue_cnt_reg;
    logic               p_vld_reg;
    logic [IDX_W-1:0]   p_idx_reg;

    logic               ai_found_reg;
    logic [IDX_W-1:0]   ai_idx_reg;
    logic [MAC_W-1:0]   ai_mac_reg;
    logic               hi_found_reg;
    logic [IDX_W-1:0]   hi_idx_reg;
    logic [IP_W-1:0]    hi_ip_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [COUNT_W-1:0] count_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [IP_W-1:0]    out_ip_reg;
    logic [MAC_W-1:0]   out_mac_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               in_accept;
    logic               issuing;
    logic               scan_done;
    logic               decide_go;

    logic [ENTRY_W-1:0] rd_data;
    logic [IP_W-1:0]    e_ip;
    logic [MAC_W-1:0]   e_mac;
    logic [TIME_W-1:0]  e_time;
    logic               e_valid;
    logic [TIME_W-1:0]  e_age;
    logic               e_expire;

    status_t            dec_status;
    logic [IP_W-1:0]    dec_old_ip;
    logic [MAC_W-1:0]   dec_old_mac;
    logic               dec_we;
    logic [IDX_W-1:0]   dec_waddr;
    logic               dec_set_valid;
    logic               ram_we;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign issuing   = (state_reg == S_SCAN) && (issue_cnt_reg != CNT_W'(CAPACITY));
    assign scan_done = (state_reg == S_SCAN) && !issuing && !p_vld_reg;
    // The result register must be free before a new result is written.
    assign decide_go = (state_reg == S_DECIDE) && (!out_valid_reg || !out_stall);

    assign ram_we = decide_go && dec_we;

    arpbt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (dec_waddr),
        .wdata ({ip_reg, mac_reg, now_reg}),
        .raddr (issue_cnt_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    assign e_ip     = rd_data[ENTRY_W-1 -: IP_W];
    assign e_mac    = rd_data[TIME_W +: MAC_W];
    assign e_time   = rd_data[TIME_W-1:0];
    assign e_valid  = valid_reg[p_idx_reg];
    assign e_age    = now_reg - e_time;
    assign e_expire = e_valid && (e_age >= delay_reg);

    always_comb
    begin
        dec_status    = STAT_EXPIRED;
        dec_old_ip    = '0;
        dec_old_mac   = '0;
        dec_we        = 1'b0;
        dec_waddr     = ai_idx_reg;
        dec_set_valid = 1'b0;
        if (cmd_reg == CMD_ADD)
        begin
            if (!ai_found_reg && !hi_found_reg)
            begin
                dec_waddr = free_idx_reg;
                if (free_found_reg)
                begin
                    dec_status    = STAT_NEW;
                    dec_we        = 1'b1;
                    dec_set_valid = 1'b1;
                end
                else
                begin
                    dec_status = STAT_FULL;
                end
            end
            else if (!hi_found_reg)
            begin
                // The IP entry keeps its IP and takes the new MAC.
                dec_status  = STAT_MAC_CHANGED;
                dec_old_ip  = ip_reg;
                dec_old_mac = ai_mac_reg;
                dec_we      = 1'b1;
            end
            else if (!ai_found_reg)
            begin
                dec_status  = STAT_IP_CHANGED;
                dec_old_ip  = hi_ip_reg;
                dec_old_mac = mac_reg;
                dec_we      = 1'b1;
                dec_waddr   = hi_idx_reg;
            end
            else if (ai_idx_reg == hi_idx_reg)
            begin
                dec_status = STAT_UNCHANGED;
                dec_we     = 1'b1;
            end
            else
            begin
                dec_status = STAT_CONFLICT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            delay_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_cnt_reg <= '0;
            p_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p_vld_reg <= issuing;
            if (issuing)
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
            if (out_valid_reg && !out_stall && !decide_go)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg     <= S_SCAN;
                        issue_cnt_reg <= '0;
                    end
                end
                S_SCAN:
                begin
                    if (scan_done)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (decide_go)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (p_vld_reg && (cmd_reg == CMD_EXPIRE) && e_expire)
            begin
                valid_reg[p_idx_reg] <= 1'b0;
            end
            if (decide_go && dec_set_valid)
            begin
                valid_reg[dec_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg        <= cmd;
            ip_reg         <= ip_addr;
            mac_reg        <= mac_addr;
            now_reg        <= now_ms;
            ai_found_reg   <= 1'b0;
            hi_found_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            count_reg      <= '0;
        end
        if (issuing)
        begin
            p_idx_reg <= issue_cnt_reg[IDX_W-1:0];
        end
        // Entries are compared in index order, so the first hit is the lowest.
        if (p_vld_reg)
        begin
            if (cmd_reg == CMD_EXPIRE)
            begin
                if (e_expire && (count_reg != COUNT_MAX))
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            else
            begin
                if (e_valid && (e_ip == ip_reg) && !ai_found_reg)
                begin
                    ai_found_reg <= 1'b1;
                    ai_idx_reg   <= p_idx_reg;
                    ai_mac_reg   <= e_mac;
                end
                if (e_valid && (e_mac == mac_reg) && !hi_found_reg)
                begin
                    hi_found_reg <= 1'b1;
                    hi_idx_reg   <= p_idx_reg;
                    hi_ip_reg    <= e_ip;
                end
                if (!e_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= p_idx_reg;
                end
            end
        end
        if (decide_go)
        begin
            out_status_reg <= dec_status;
            out_ip_reg     <= dec_old_ip;
            out_mac_reg    <= dec_old_mac;
            out_count_reg  <= (cmd_reg == CMD_EXPIRE) ? count_reg : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign old_ip_addr   = out_ip_reg;
    assign old_mac_addr  = out_mac_reg;
    assign expired_count = out_count_reg;

    `ARPBT_ASSERT(a_accept_starts_scan, in_accept |=> (state_reg == S_SCAN),
        "accepted item did not start a scan")
    `ARPBT_ASSERT(a_count_only_expire,
        (out_valid && (status != STAT_EXPIRED)) |-> (expired_count == '0),
        "add result carries a nonzero expired count")
    `ARPBT_ASSERT(a_old_zero,
        (out_valid && (status != STAT_MAC_CHANGED) && (status != STAT_IP_CHANGED))
            |-> ((old_ip_addr == '0) && (old_mac_addr == '0)),
        "old binding reported for a result without a change")
    `ARPBT_ASSERT(a_no_write_in_scan, (state_reg == S_SCAN) |-> !ram_we,
        "table written while a scan is reading it")
    `ARPBT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_valid && (state_reg == S_IDLE)),
        "block not idle during reset")

endmodule

`default_nettype wire

>>> src/arpbt_ram.sv
// ----------------------------------------------------------------------------
// arpbt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module arpbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> tb/arp_binding_table_checker.sv
// ----------------------------------------------------------------------------
// arp_binding_table_checker
// Watches the channels of the ARP binding table, keeps its own copy of the
// bindings and the expiry delay, and compares every result item with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module arp_binding_table_checker
    import arpbt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [TIME_W-1:0]  cfg_data,

    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic               cmd,
    input  wire logic [IP_W-1:0]    ip_addr,
    input  wire logic [MAC_W-1:0]   mac_addr,
    input  wire logic [TIME_W-1:0]  now_ms,

    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [2:0]         status,
    input  wire logic [IP_W-1:0]    old_ip_addr,
    input  wire logic [MAC_W-1:0]   old_mac_addr,
    input  wire logic [COUNT_W-1:0] expired_count,

    output int                      error_count,
    output int                      pending_results
);

    typedef struct packed {
        status_t             status;
        logic [IP_W-1:0]     old_ip;
        logic [MAC_W-1:0]    old_mac;
        logic [COUNT_W-1:0]  freed;
    } binding_result_t;

    logic                bind_valid [CAPACITY];
    logic [IP_W-1:0]     bind_ip    [CAPACITY];
    logic [MAC_W-1:0]    bind_mac   [CAPACITY];
    logic [TIME_W-1:0]   bind_seen  [CAPACITY];
    logic [TIME_W-1:0]   delay_ms;

    binding_result_t     expected_results [$];
    binding_result_t     oldest;
    int                  errors = 0;
    int                  results_seen = 0;

    function automatic int find_by_ip(input logic [IP_W-1:0] ip);
        for (int i = 0; i < CAPACITY; i++)
            if (bind_valid[i] && bind_ip[i] == ip)
                return i;
        return -1;
    endfunction

    function automatic int find_by_mac(input logic [MAC_W-1:0] mac);
        for (int i = 0; i < CAPACITY; i++)
            if (bind_valid[i] && bind_mac[i] == mac)
                return i;
        return -1;
    endfunction

    function automatic int find_free_slot();
        for (int i = 0; i < CAPACITY; i++)
            if (!bind_valid[i])
                return i;
        return -1;
    endfunction

    // Applies one accepted item to the table copy and returns its result.
    function automatic binding_result_t apply_binding_item(
        input logic              c,
        input logic [IP_W-1:0]   ip,
        input logic [MAC_W-1:0]  mac,
        input logic [TIME_W-1:0] now
    );
        binding_result_t   r;
        int                ip_hit;
        int                mac_hit;
        int                slot;
        logic [TIME_W-1:0] age;
        r = '0;
        if (c == CMD_EXPIRE)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (bind_valid[i])
                begin
                    // Modular subtraction keeps the age right across a clock wrap.
                    age = now - bind_seen[i];
                    if (age >= delay_ms)
                    begin
                        bind_valid[i] = 1'b0;
                        if (r.freed != COUNT_MAX)
                            r.freed = r.freed + 1'b1;
                    end
                end
            end
            r.status = STAT_EXPIRED;
        end
        else
        begin
            ip_hit  = find_by_ip(ip);
            mac_hit = find_by_mac(mac);
            if (ip_hit < 0 && mac_hit < 0)
            begin
                slot = find_free_slot();
                if (slot < 0)
                    r.status = STAT_FULL;
                else
                begin
                    bind_valid[slot] = 1'b1;
                    bind_ip[slot]    = ip;
                    bind_mac[slot]   = mac;
                    bind_seen[slot]  = now;
                    r.status         = STAT_NEW;
                end
            end
            else if (ip_hit >= 0 && mac_hit < 0)
            begin
                r.old_ip          = bind_ip[ip_hit];
                r.old_mac         = bind_mac[ip_hit];
                bind_mac[ip_hit]  = mac;
                bind_seen[ip_hit] = now;
                r.status          = STAT_MAC_CHANGED;
            end
            else if (ip_hit < 0)
            begin
                r.old_ip           = bind_ip[mac_hit];
                r.old_mac          = bind_mac[mac_hit];
                bind_ip[mac_hit]   = ip;
                bind_seen[mac_hit] = now;
                r.status           = STAT_IP_CHANGED;
            end
            else if (ip_hit == mac_hit)
            begin
                bind_seen[ip_hit] = now;
                r.status          = STAT_UNCHANGED;
            end
            else
                r.status = STAT_CONFLICT;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("result item %0d: %s is %0h, expected %0h", results_seen, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
                bind_valid[i] = 1'b0;
            delay_ms = DELAY_RESET;
            expected_results.delete();
            pending_results <= 0;
        end
        else
        begin
            // A result always belongs to an item accepted at an earlier edge.
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("status of an unexpected item", 64'(status), 64'd0);
                else
                begin
                    oldest = expected_results.pop_front();
                    if (status !== oldest.status)
                        report_mismatch("status", 64'(status), 64'(oldest.status));
                    if (old_ip_addr !== oldest.old_ip)
                        report_mismatch("old_ip_addr", 64'(old_ip_addr), 64'(oldest.old_ip));
                    if (old_mac_addr !== oldest.old_mac)
                        report_mismatch("old_mac_addr", 64'(old_mac_addr),
                                        64'(oldest.old_mac));
                    if (expired_count !== oldest.freed)
                        report_mismatch("expired_count", 64'(expired_count),
                                        64'(oldest.freed));
                end
                results_seen++;
            end
            if (in_valid && !in_stall)
                expected_results.push_back(
                    apply_binding_item(cmd, ip_addr, mac_addr, now_ms));
            if (cfg_valid && cfg_ready)
                delay_ms = cfg_data;
            pending_results <= expected_results.size();
        end
        error_count <= errors;
    end

endmodule

>>> tb/tb_arp_binding_table_unit.sv
// ----------------------------------------------------------------------------
// tb_arp_binding_table_unit
// Drives add and expire items into the ARP binding table under several
// expiry delays and idling patterns, with a checker alongside the block.
// ----------------------------------------------------------------------------
module tb_arp_binding_table_unit
    import arpbt_pkg::*;
;

    localparam int POOL_SIZE      = 72;
    localparam int PHASE_ITEMS    = 240;
    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [TIME_W-1:0]  cfg_data = '0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               cmd = CMD_ADD;
    logic [IP_W-1:0]    ip_addr = '0;
    logic [MAC_W-1:0]   mac_addr = '0;
    logic [TIME_W-1:0]  now_ms = '0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         status;
    logic [IP_W-1:0]    old_ip_addr;
    logic [MAC_W-1:0]   old_mac_addr;
    logic [COUNT_W-1:0] expired_count;

    int                 mismatches;
    int                 pending_results;

    int                 sender_idle_pct = 0;
    int                 receiver_stall_pct = 0;
    int                 quiet_cycles = 0;

    logic [IP_W-1:0]    ip_pool  [POOL_SIZE];
    logic [MAC_W-1:0]   mac_pool [POOL_SIZE];
    logic [TIME_W-1:0]  time_now;

    always #4 clk = ~clk;

    arp_binding_table_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .ip_addr       (ip_addr),
        .mac_addr      (mac_addr),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .old_ip_addr   (old_ip_addr),
        .old_mac_addr  (old_mac_addr),
        .expired_count (expired_count)
    );

    arp_binding_table_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .ip_addr         (ip_addr),
        .mac_addr        (mac_addr),
        .now_ms          (now_ms),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .old_ip_addr     (old_ip_addr),
        .old_mac_addr    (old_mac_addr),
        .expired_count   (expired_count),
        .error_count     (mismatches),
        .pending_results (pending_results)
    );

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);

    // The run is stuck if no channel moves an item for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("** arp_binding_table_unit: FAILED **");
            $finish;
        end
    end

    function automatic logic [MAC_W-1:0] random_mac();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    task automatic send_item(input logic c, input logic [IP_W-1:0] ip,
                             input logic [MAC_W-1:0] mac, input logic [TIME_W-1:0] now);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        ip_addr  <= ip;
        mac_addr <= mac;
        now_ms   <= now;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Holds the sender back until every predicted result item has come out.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    task automatic write_delay(input logic [TIME_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // About half are pairs that stay bound to each other, so the table fills and
    // refreshes; the rest rebinds, conflicts, fresh pairs and expiries.
    task automatic send_random(input bit lead_expire, input bit fresh_only);
        int                pick;
        int                k;
        int                j;
        logic              c;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] now;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, POOL_SIZE - 1);
        j    = $urandom_range(0, POOL_SIZE - 1);
        c    = CMD_ADD;
        ip   = ip_pool[k];
        mac  = mac_pool[k];
        if (lead_expire || (!fresh_only && pick < 10))
        begin
            c   = CMD_EXPIRE;
            ip  = $urandom();
            mac = random_mac();
        end
        else if (fresh_only || pick < 18)
        begin
            ip  = $urandom();
            mac = random_mac();
        end
        else if (pick < 30)
            mac = mac_pool[j];
        else if (pick < 38)
            mac = random_mac();
        else if (pick < 46)
            ip = $urandom();
        else if (pick < 52)
        begin
            ip_pool[k]  = $urandom();
            mac_pool[k] = random_mac();
            ip          = ip_pool[k];
            mac         = mac_pool[k];
        end
        now = ($urandom_range(0, 49) == 0) ? TIME_W'($urandom()) : time_now;
        send_item(c, ip, mac, now);
    endtask

    task automatic run_phase(input logic [TIME_W-1:0] delay, input int idle_pct,
                             input int stall_pct, input int fill_items,
                             input bit lead_expire);
        logic [TIME_W:0] step_lim;
        write_delay(delay);
        sender_idle_pct    <= idle_pct;
        receiver_stall_pct <= stall_pct;
        // Time advances in steps scaled to the delay so that entries both
        // survive and age out.
        step_lim = ({1'b0, delay} >> 4) + 33'd3;
        if (step_lim[TIME_W])
            step_lim = {1'b0, {TIME_W{1'b1}}};
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (n > 0 && $urandom_range(0, 149) == 0)
                drain();
            time_now = time_now + $urandom_range(0, step_lim[TIME_W-1:0]);
            send_random(lead_expire && n == 0, n < fill_items);
        end
    endtask

    initial
    begin
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            ip_pool[i]  = $urandom();
            mac_pool[i] = random_mac();
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, every kind of add but a full table, and ages at and across the wrap,
        // first with the reset delay.
        send_item(CMD_ADD, '0, '0, '0);
        send_item(CMD_ADD, '1, '1, 32'hFFFF_FF00);
        send_item(CMD_ADD, '0, '0, 32'd100);
        send_item(CMD_ADD, '0, 48'd1, 32'd200);
        send_item(CMD_ADD, 32'd7, 48'd1, 32'd300);
        send_item(CMD_ADD, 32'd7, '1, 32'd400);
        send_item(CMD_EXPIRE, '1, '1, 32'h0000_EA00);
        send_item(CMD_EXPIRE, '0, '0, 32'd60300);

        // With the largest delay only an age of all ones expires.
        write_delay('1);
        send_item(CMD_ADD, 32'h8000_0000, 48'h8000_0000_0000, 32'd5);
        send_item(CMD_EXPIRE, '0, '0, 32'd4);
        send_item(CMD_ADD, 32'h8000_0000, 48'h8000_0000_0000, 32'd5);
        send_item(CMD_EXPIRE, '1, '0, 32'd5);

        // A delay of zero frees everything, even an age of zero.
        write_delay('0);
        send_item(CMD_EXPIRE, '0, '1, 32'd0);
        send_item(CMD_EXPIRE, '0, '0, 32'd0);
        send_item(CMD_ADD, 32'h1234_5678, 48'hABCD_EF01_2345, 32'h7FFF_FFFF);
        send_item(CMD_EXPIRE, '1, '1, 32'h7FFF_FFFF);

        time_now = $urandom();
        run_phase('1, 0, 0, 66, 1'b0);
        run_phase('0, 64, 0, 0, 1'b1);
        time_now = 32'hFFFF_F000;
        run_phase(32'd1000, 0, 64, 0, 1'b0);
        run_phase(DELAY_RESET, 32, 32, 0, 1'b0);
        run_phase(32'd1, 0, 0, 0, 1'b0);
        run_phase(32'h8000_0000, 64, 0, 0, 1'b0);
        run_phase(TIME_W'($urandom()), 0, 64, 0, 1'b0);
        run_phase(32'd50000, 32, 32, 0, 1'b0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** arp_binding_table_unit: PASSED **");
        else
            $display("** arp_binding_table_unit: FAILED **");
        $finish;
    end

endmodule
